// ===== hdl/bmp_pkg.sv =====
package bmp_pkg;

    // Defaults of the top-level parameters
    localparam int DEFAULT_MAX_FRAME_WIDTH = 2048;
    localparam int DEFAULT_MAX_BLOCK       = 16;
    localparam int DEFAULT_SAMPLE_BITS     = 16;

    // Configuration port geometry and register widths
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;
    localparam int FRAME_REG_BITS = 12;
    localparam int BLOCK_REG_BITS = 5;

    // Register reset values
    localparam int RESET_FRAME_WIDTH  = 640;
    localparam int RESET_FRAME_HEIGHT = 480;
    localparam int RESET_BLOCK_WIDTH  = 4;
    localparam int RESET_BLOCK_HEIGHT = 4;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_BLOCK_WIDTH  = 2'd2,
        REG_BLOCK_HEIGHT = 2'd3
    } cfg_reg_t;

    // Status of the grid-size divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== hdl/bmp_ram.sv =====
module bmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port; a read at the written address returns old data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ===== hdl/bmp_div.sv =====
module bmp_div #(
    parameter int DIVIDEND_BITS = 12,
    parameter int DIVISOR_BITS  = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [DIVIDEND_BITS-1:0]   dividend,
    input  logic [DIVISOR_BITS-1:0]    divisor,
    output logic [DIVIDEND_BITS-1:0]   quotient,
    output bmp_pkg::div_status_t       status
);

    import bmp_pkg::*;

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic [CNT_BITS-1:0]      count_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVIDEND_BITS-1:0] quo_reg;

    logic [DIVISOR_BITS:0]    trial;
    logic                     fits;
    logic [DIVISOR_BITS:0]    diff;

    // One restoring step: shift in the next dividend bit and try a subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        fits  = trial >= {1'b0, divisor};
        diff  = trial - {1'b0, divisor};
    end

    // Control: load on start, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_BITS'(DIVIDEND_BITS);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CNT_BITS'(1);
                if (count_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== hdl/block_max_pool.sv =====
// Non-overlapping 2-D max pooling over a raster-order sample stream.
// Input channel (sample, in_valid, in_ready): one pixel per transfer, raster
// order. Output channel (pooled, out_column, out_row, frame_done, out_valid,
// out_ready): one transfer per whole block, in raster order of the output
// grid; frame_done marks the last block of the frame. Columns and rows
// beyond whole blocks are consumed and dropped.
// Configuration channel (cfg_index, cfg_data, cfg_valid, cfg_ready): write
// registers only while no transfer is pending. Every write restarts the
// grid-size dividers, which hold in_ready low until the new grid sizes are
// captured.
// Throughput: one sample per cycle while in_ready is high, with one
// read-modify-write of the line store per block-row segment (read at accept,
// write in the cycle after, with a forwarding register for back-to-back hits
// on one entry). Results pass the update stage, then the result buffer.
// Reset: registers take their defaults and all counters return to zero; the
// line store needs no clearing pass, as a block's first row writes it first.
// Stall: results queue in a two-entry buffer; in_ready drops when a further
// result could not be held, and nothing is lost.
module block_max_pool #(
    parameter int MAX_FRAME_WIDTH = bmp_pkg::DEFAULT_MAX_FRAME_WIDTH,
    parameter int MAX_BLOCK       = bmp_pkg::DEFAULT_MAX_BLOCK,
    parameter int SAMPLE_BITS     = bmp_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       pooled,
    output logic [$clog2(MAX_FRAME_WIDTH)-1:0]  out_column,
    output logic [$clog2(MAX_FRAME_WIDTH)-1:0]  out_row,
    output logic                                frame_done,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bmp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bmp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import bmp_pkg::*;

    localparam int COL_BITS = $clog2(MAX_FRAME_WIDTH);
    localparam int FW_BITS  = $clog2(MAX_FRAME_WIDTH + 1);
    localparam int BLK_BITS = $clog2(MAX_BLOCK + 1);

    localparam int RESET_FW = RESET_FRAME_WIDTH > MAX_FRAME_WIDTH ?
                              MAX_FRAME_WIDTH : RESET_FRAME_WIDTH;
    localparam int RESET_FH = RESET_FRAME_HEIGHT > MAX_FRAME_WIDTH ?
                              MAX_FRAME_WIDTH : RESET_FRAME_HEIGHT;
    localparam int RESET_BW = RESET_BLOCK_WIDTH > MAX_BLOCK ? MAX_BLOCK : RESET_BLOCK_WIDTH;
    localparam int RESET_BH = RESET_BLOCK_HEIGHT > MAX_BLOCK ? MAX_BLOCK : RESET_BLOCK_HEIGHT;
    localparam int RESET_OW = RESET_FW / RESET_BW;
    localparam int RESET_OH = RESET_FH / RESET_BH;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] pooled;
        logic [COL_BITS-1:0]           column;
        logic [COL_BITS-1:0]           row;
        logic                          done;
    } result_t;

    // Configuration registers
    logic [FRAME_REG_BITS-1:0] frame_width_reg;
    logic [FRAME_REG_BITS-1:0] frame_height_reg;
    logic [BLOCK_REG_BITS-1:0] block_width_reg;
    logic [BLOCK_REG_BITS-1:0] block_height_reg;
    logic                      div_start_reg;
    logic [FW_BITS-1:0]        ow_reg;
    logic [FW_BITS-1:0]        oh_reg;

    // Position state
    logic [FW_BITS-1:0]  pc_reg, pc_next;
    logic [FW_BITS-1:0]  pr_reg, pr_next;
    logic [BLK_BITS-1:0] cib_reg, cib_next;
    logic [BLK_BITS-1:0] rib_reg, rib_next;
    logic [FW_BITS-1:0]  gc_reg, gc_next;
    logic [FW_BITS-1:0]  gr_reg, gr_next;
    logic signed [SAMPLE_BITS-1:0] seg_reg, seg_next;

    // Store update stage
    logic                          s1_valid_reg;
    logic [COL_BITS-1:0]           s1_addr_reg;
    logic signed [SAMPLE_BITS-1:0] s1_seg_reg;
    logic                          s1_first_reg;
    logic                          s1_emit_reg;
    logic [COL_BITS-1:0]           s1_row_reg;
    logic                          s1_done_reg;
    logic                          fwd_valid_reg;
    logic signed [SAMPLE_BITS-1:0] fwd_data_reg;

    // Result buffer
    result_t    buf_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    logic [FW_BITS-1:0]  fw, fh;
    logic [BLK_BITS-1:0] bw, bh;
    logic [FW_BITS-1:0]  quo_w, quo_h;
    div_status_t         st_w, st_h;
    logic                cfg_busy;
    logic                accept;
    logic                push, pop;
    logic [2:0]          pending;
    logic                in_block, col_end, row_end, last_block;
    logic signed [SAMPLE_BITS-1:0] seg_new;
    logic                load_s1;
    logic                ram_rd_en;
    logic signed [SAMPLE_BITS-1:0] ram_rd_data;
    logic signed [SAMPLE_BITS-1:0] cell_old, cell_new;
    logic [FW_BITS-1:0]  pc_inc;
    logic [BLK_BITS-1:0] cib_inc, rib_inc;

    // Clamp register values to their legal ranges
    always_comb
    begin
        if (frame_width_reg == '0)
            fw = FW_BITS'(1);
        else if (int'(frame_width_reg) > MAX_FRAME_WIDTH)
            fw = FW_BITS'(MAX_FRAME_WIDTH);
        else
            fw = FW_BITS'(frame_width_reg);
        if (frame_height_reg == '0)
            fh = FW_BITS'(1);
        else if (int'(frame_height_reg) > MAX_FRAME_WIDTH)
            fh = FW_BITS'(MAX_FRAME_WIDTH);
        else
            fh = FW_BITS'(frame_height_reg);
        if (block_width_reg == '0)
            bw = BLK_BITS'(1);
        else if (int'(block_width_reg) > MAX_BLOCK)
            bw = BLK_BITS'(MAX_BLOCK);
        else
            bw = BLK_BITS'(block_width_reg);
        if (block_height_reg == '0)
            bh = BLK_BITS'(1);
        else if (int'(block_height_reg) > MAX_BLOCK)
            bh = BLK_BITS'(MAX_BLOCK);
        else
            bh = BLK_BITS'(block_height_reg);
    end

    // Grid sizes: output columns and rows per frame
    bmp_div #(
        .DIVIDEND_BITS (FW_BITS),
        .DIVISOR_BITS  (BLK_BITS)
    ) u_div_w (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (fw),
        .divisor  (bw),
        .quotient (quo_w),
        .status   (st_w)
    );

    bmp_div #(
        .DIVIDEND_BITS (FW_BITS),
        .DIVISOR_BITS  (BLK_BITS)
    ) u_div_h (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (fh),
        .divisor  (bh),
        .quotient (quo_h),
        .status   (st_h)
    );

    // Take register writes and capture the grid sizes when the dividers finish
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_REG_BITS'(RESET_FRAME_WIDTH);
            frame_height_reg <= FRAME_REG_BITS'(RESET_FRAME_HEIGHT);
            block_width_reg  <= BLOCK_REG_BITS'(RESET_BLOCK_WIDTH);
            block_height_reg <= BLOCK_REG_BITS'(RESET_BLOCK_HEIGHT);
            div_start_reg    <= 1'b0;
            ow_reg           <= FW_BITS'(RESET_OW);
            oh_reg           <= FW_BITS'(RESET_OH);
        end
        else
        begin
            div_start_reg <= cfg_valid;
            if (cfg_valid)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FRAME_REG_BITS-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FRAME_REG_BITS-1:0];
                    REG_BLOCK_WIDTH:  block_width_reg  <= cfg_data[BLOCK_REG_BITS-1:0];
                    REG_BLOCK_HEIGHT: block_height_reg <= cfg_data[BLOCK_REG_BITS-1:0];
                    default:          ;
                endcase
            end
            if (st_w.done)
                ow_reg <= quo_w;
            if (st_h.done)
                oh_reg <= quo_h;
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg_busy  = div_start_reg | st_w.busy | st_w.done | st_h.busy | st_h.done;

    // Accept only when a further result would still fit in the buffer and the grid sizes are not being recomputed
    assign push     = s1_valid_reg & s1_emit_reg;
    assign pop      = out_valid & out_ready;
    assign pending  = 3'(count_reg) + 3'(push) - 3'(pop);
    assign in_ready = !cfg_busy && (pending <= 3'd1);
    assign accept   = in_valid & in_ready;

    // Classify the sample and advance the raster counters
    always_comb
    begin
        pc_inc     = pc_reg + FW_BITS'(1);
        cib_inc    = cib_reg + BLK_BITS'(1);
        rib_inc    = rib_reg + BLK_BITS'(1);
        in_block   = (gc_reg < ow_reg) && (gr_reg < oh_reg);
        seg_new    = (cib_reg == '0 || sample > seg_reg) ? sample : seg_reg;
        col_end    = cib_inc >= bw;
        row_end    = rib_inc >= bh;
        last_block = (gc_reg + FW_BITS'(1) == ow_reg) && (gr_reg + FW_BITS'(1) == oh_reg);
        load_s1    = accept && in_block && col_end;

        seg_next = in_block ? seg_new : seg_reg;
        pc_next  = pc_inc;
        pr_next  = pr_reg;
        cib_next = cib_inc;
        rib_next = rib_reg;
        gc_next  = gc_reg;
        gr_next  = gr_reg;
        if (col_end)
        begin
            cib_next = '0;
            gc_next  = gc_reg + FW_BITS'(1);
        end
        if (pc_inc >= fw)
        begin
            pc_next  = '0;
            cib_next = '0;
            gc_next  = '0;
            pr_next  = pr_reg + FW_BITS'(1);
            rib_next = rib_inc;
            if (row_end)
            begin
                rib_next = '0;
                gr_next  = gr_reg + FW_BITS'(1);
            end
            if (pr_reg + FW_BITS'(1) >= fh)
            begin
                pr_next  = '0;
                rib_next = '0;
                gr_next  = '0;
                seg_next = '0;
            end
        end
    end

    // Hold position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= '0;
            pr_reg  <= '0;
            cib_reg <= '0;
            rib_reg <= '0;
            gc_reg  <= '0;
            gr_reg  <= '0;
            seg_reg <= '0;
        end
        else if (accept)
        begin
            pc_reg  <= pc_next;
            pr_reg  <= pr_next;
            cib_reg <= cib_next;
            rib_reg <= rib_next;
            gc_reg  <= gc_next;
            gr_reg  <= gr_next;
            seg_reg <= seg_next;
        end
    end

    // Line store of running column maxima, one entry per output column
    assign ram_rd_en = load_s1 && (rib_reg != '0);

    bmp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_FRAME_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (cell_new),
        .rd_en   (ram_rd_en),
        .rd_addr (gc_reg[COL_BITS-1:0]),
        .rd_data (ram_rd_data)
    );

    // Merge the row segment into the stored column maximum
    always_comb
    begin
        cell_old = fwd_valid_reg ? fwd_data_reg : ram_rd_data;
        cell_new = (s1_first_reg || s1_seg_reg > cell_old) ? s1_seg_reg : cell_old;
    end

    // Control of the update stage and the forwarding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= load_s1;
            fwd_valid_reg <= ram_rd_en && s1_valid_reg &&
                             (s1_addr_reg == gc_reg[COL_BITS-1:0]);
        end
    end

    // Payload of the update stage
    always_ff @(posedge clk)
    begin
        fwd_data_reg <= cell_new;
        if (load_s1)
        begin
            s1_addr_reg  <= gc_reg[COL_BITS-1:0];
            s1_seg_reg   <= seg_new;
            s1_first_reg <= (rib_reg == '0);
            s1_emit_reg  <= row_end;
            s1_row_reg   <= gr_reg[COL_BITS-1:0];
            s1_done_reg  <= last_block;
        end
    end

    // Result buffer pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    // Result buffer entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= '{pooled: cell_new, column: s1_addr_reg,
                                     row: s1_row_reg, done: s1_done_reg};
        end
    end

    assign out_valid  = count_reg != '0;
    assign pooled     = buf_reg[rd_ptr_reg].pooled;
    assign out_column = buf_reg[rd_ptr_reg].column;
    assign out_row    = buf_reg[rd_ptr_reg].row;
    assign frame_done = buf_reg[rd_ptr_reg].done;

`ifndef SYNTHESIS
    // The buffer never overflows: a push into a full buffer comes with a pop
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && count_reg == 2'd2) |-> pop)
        else $error("result buffer overflow");

    // The buffer holds at most two results
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("result buffer count out of range");

    // Forwarded data only serves an update in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> s1_valid_reg)
        else $error("forwarding without an update");

    // No sample enters in the cycle the width divider starts
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(st_w.busy) |-> !accept)
        else $error("sample accepted during divide");

    // The last block of a frame sits in the last grid column
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> (FW_BITS'(out_column) == ow_reg - FW_BITS'(1)))
        else $error("frame end off the last grid column");
`endif

endmodule
